// File: design/rlirq_pkg.sv
// rlirq_pkg: shared types and constants for the raster line interrupt register block
// item structs, operation codes, register offsets and raster timing constants
// no dependencies
package rlirq_pkg;

  // raster geometry
  localparam int unsigned LINE_W          = 9;
  localparam logic [LINE_W-1:0] LINES_PER_FRAME = 9'd312;
  localparam logic [LINE_W-1:0] BADLINE_FIRST   = 9'h030;
  localparam logic [LINE_W-1:0] BADLINE_LAST    = 9'h0f7;

  // register file geometry
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned REG_DEPTH = 49;
  localparam logic [IDX_W-1:0] REG_COUNT = 6'd49;

  // register offsets with side effects
  localparam logic [IDX_W-1:0] REG_CONTROL = 6'h11;
  localparam logic [IDX_W-1:0] REG_RASTER  = 6'h12;
  localparam logic [IDX_W-1:0] REG_STATUS  = 6'h19;
  localparam logic [IDX_W-1:0] REG_MASK    = 6'h1a;

  // status bits set on a raster match
  localparam logic [DATA_W-1:0] RASTER_FLAGS = 8'b1000_0001;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CHECK   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              raster_match;
    logic              badline;
    logic [LINE_W-1:0] scanline;
  } out_item_t;

  // register file write port
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

endpackage

// File: design/raster_line_irq_register_block.sv
// raster_line_irq_register_block: top level with input register, execute logic and result register
// instantiates rlirq_regfile and rlirq_exec
// depends on rlirq_pkg
//
//  channel | signals                            | direction | payload
//  --------+------------------------------------+-----------+--------------------
//  in      | in_valid_i, in_ready_o, in_data_i  | to block  | in_item_t
//  out     | out_valid_o, out_ready_i, out_data_o | from block | out_item_t
//
// one item per clock while the result side keeps up; an accepted item passes through the input
// register and then the result register; the register file read is issued at acceptance
// and its registered data meets the item in the input register
// reset clears the raster state, the register file valid flags and both stage valids
// a stalled result holds the input register; a new item is taken whenever the input
// register is empty or moves into the result register in the same cycle
module raster_line_irq_register_block (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rlirq_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rlirq_pkg::out_item_t out_data_o
);
  import rlirq_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      in_fire;
  logic      s1_fire;
  rf_wr_t    rf_wr;
  logic [DATA_W-1:0] rf_rdata;
  out_item_t result;

  // handshake
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // register file, read at acceptance
  rlirq_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_data_i.reg_index),
    .wr_i      (rf_wr),
    .rd_data_o (rf_rdata)
  );

  // raster state and result logic
  rlirq_exec u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (s1_item_q),
    .commit_i   (s1_fire),
    .rf_rdata_i (rf_rdata),
    .rf_wr_o    (rf_wr),
    .result_o   (result)
  );

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
    end
    if (s1_fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

`ifndef ASSERT_OFF
  a_fire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("processed item did not reach the result register");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input refused with empty input register");

  a_out_scanline_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.scanline < LINES_PER_FRAME))
    else $error("result scanline out of frame");
`endif

endmodule

// File: design/rlirq_regfile.sv
// rlirq_regfile: 49-entry byte register file with registered read and per-entry valid bits
// entries never written read as zero; a write leaving the execute stage bypasses to a same-edge read
// depends on rlirq_pkg
module rlirq_regfile (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [rlirq_pkg::IDX_W-1:0]     rd_addr_i,
  input  rlirq_pkg::rf_wr_t               wr_i,
  output logic [rlirq_pkg::DATA_W-1:0]    rd_data_o
);
  import rlirq_pkg::*;

  logic [DATA_W-1:0]    mem [REG_DEPTH];
  logic [REG_DEPTH-1:0] valid_q;
  logic [DATA_W-1:0]    rdata_q;
  logic                 rvalid_q;
  logic                 rvalid_d;
  logic                 rd_hit;
  logic                 rd_in_range;

  // read address checks
  assign rd_in_range = rd_addr_i < REG_COUNT;
  assign rd_hit      = wr_i.en && (wr_i.addr == rd_addr_i);

  always_comb begin
    rvalid_d = 1'b0;
    if (rd_in_range) begin
      rvalid_d = rd_hit || valid_q[rd_addr_i];
    end
  end

  // storage array and read port, write bypass on same address
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i && rd_in_range) begin
      if (rd_hit) begin
        rdata_q <= wr_i.data;
      end else begin
        rdata_q <= mem[rd_addr_i];
      end
    end
  end

  // written-entry flags and read qualifier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= rvalid_d;
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

// File: design/rlirq_exec.sv
// rlirq_exec: raster state (line, compare, flags, mask, control copy) and result logic
// works on the item held in the input register; state commits when the item moves on
// depends on rlirq_pkg
module rlirq_exec (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rlirq_pkg::in_item_t          item_i,
  input  logic                         commit_i,
  input  logic [rlirq_pkg::DATA_W-1:0] rf_rdata_i,
  output rlirq_pkg::rf_wr_t            rf_wr_o,
  output rlirq_pkg::out_item_t         result_o
);
  import rlirq_pkg::*;

  op_e               op;
  logic              in_range;
  logic [LINE_W:0]   line_inc;
  logic [LINE_W-1:0] line_q, line_d;
  logic [LINE_W-1:0] cmp_q, cmp_d;
  logic [DATA_W-1:0] flags_q, flags_d;
  logic [DATA_W-1:0] mask_q, mask_d;
  logic [6:0]        ctrl_q, ctrl_d;
  logic [DATA_W-1:0] rd_data;
  logic              match;
  logic              badline;

  assign op       = op_e'(item_i.opcode);
  assign in_range = item_i.reg_index < REG_COUNT;
  assign line_inc = {1'b0, line_q} + {{LINE_W{1'b0}}, 1'b1};

  // next state and read value for the current item
  always_comb begin
    line_d  = line_q;
    cmp_d   = cmp_q;
    flags_d = flags_q;
    mask_d  = mask_q;
    ctrl_d  = ctrl_q;
    rd_data = '0;
    match   = 1'b0;
    case (op)
      OP_WRITE: begin
        if (in_range) begin
          case (item_i.reg_index)
            REG_CONTROL: begin
              cmp_d[LINE_W-1] = item_i.write_data[7];
              ctrl_d          = item_i.write_data[6:0];
            end
            REG_RASTER: cmp_d[7:0] = item_i.write_data;
            REG_STATUS: flags_d    = flags_q & ~item_i.write_data;
            REG_MASK:   mask_d     = item_i.write_data;
            default: ;
          endcase
        end
      end
      OP_READ: begin
        if (in_range) begin
          case (item_i.reg_index)
            REG_CONTROL: rd_data = {line_q[LINE_W-1], ctrl_q};
            REG_RASTER:  rd_data = line_q[7:0];
            REG_STATUS:  rd_data = flags_q;
            REG_MASK:    rd_data = mask_q;
            default:     rd_data = rf_rdata_i;
          endcase
        end
      end
      OP_ADVANCE: begin
        if (line_inc >= {1'b0, LINES_PER_FRAME}) begin
          line_d = '0;
        end else begin
          line_d = line_inc[LINE_W-1:0];
        end
      end
      OP_CHECK: begin
        if (line_q == cmp_q) begin
          flags_d = flags_q | RASTER_FLAGS;
          match   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // badline on the state after this item
  assign badline = (line_d >= BADLINE_FIRST) && (line_d <= BADLINE_LAST) &&
                   (line_d[2:0] == ctrl_d[2:0]) && ctrl_d[4];

  // register file write for every in-range store, special offsets included
  assign rf_wr_o.en   = commit_i && (op == OP_WRITE) && in_range;
  assign rf_wr_o.addr = item_i.reg_index;
  assign rf_wr_o.data = item_i.write_data;

  assign result_o.read_data    = rd_data;
  assign result_o.raster_match = match;
  assign result_o.badline      = badline;
  assign result_o.scanline     = line_d;

  // raster state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= '0;
      cmp_q   <= '0;
      flags_q <= '0;
      mask_q  <= '0;
      ctrl_q  <= '0;
    end else if (commit_i) begin
      line_q  <= line_d;
      cmp_q   <= cmp_d;
      flags_q <= flags_d;
      mask_q  <= mask_d;
      ctrl_q  <= ctrl_d;
    end
  end

`ifndef ASSERT_OFF
  a_line_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q < LINES_PER_FRAME)
    else $error("scanline left the frame");

  a_match_sets_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && match |=> flags_q[7] && flags_q[0])
    else $error("raster match did not set status flags");

  a_line_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && (op != OP_ADVANCE) |=> $stable(line_q))
    else $error("scanline moved without an advance");
`endif

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking testbench for raster_line_irq_register_block
// predicts every result item from its own copy of the register and raster state
// depends on rlirq_pkg and the design under design/
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rlirq_pkg::*;

  localparam int unsigned ITEM_TOTAL  = 1150;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_WAIT  = 10;

  // tracks register, scanline and flag state, and the results still owed
  class raster_irq_tracker;
    logic [DATA_W-1:0] regs [REG_DEPTH];
    logic [LINE_W-1:0] scan_line;
    logic [LINE_W-1:0] cmp_line;
    logic [DATA_W-1:0] flags;
    logic [DATA_W-1:0] mask;
    out_item_t         owed [$];
    int unsigned       errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      scan_line = '0;
      cmp_line  = '0;
      flags     = '0;
      mask      = '0;
      errors    = 0;
    endfunction

    // apply one accepted item and queue the result it must produce
    function void note_item(in_item_t it);
      out_item_t         res;
      logic [DATA_W-1:0] ctl;
      int unsigned       nxt;
      res = '0;
      case (op_e'(it.opcode))
        OP_WRITE: begin
          if (it.reg_index < REG_COUNT) begin
            case (it.reg_index)
              REG_CONTROL: cmp_line[8] = it.write_data[7];
              REG_RASTER:  cmp_line[7:0] = it.write_data;
              REG_STATUS:  flags = flags & ~it.write_data;
              REG_MASK:    mask = it.write_data;
              default: ;
            endcase
            regs[it.reg_index] = it.write_data;
          end
        end
        OP_READ: begin
          if (it.reg_index < REG_COUNT) begin
            case (it.reg_index)
              REG_CONTROL: res.read_data = {scan_line[8], regs[REG_CONTROL][6:0]};
              REG_RASTER:  res.read_data = scan_line[7:0];
              REG_STATUS:  res.read_data = flags;
              REG_MASK:    res.read_data = mask;
              default:     res.read_data = regs[it.reg_index];
            endcase
          end
        end
        OP_ADVANCE: begin
          nxt = scan_line + 1;
          scan_line = (nxt >= LINES_PER_FRAME) ? '0 : nxt[LINE_W-1:0];
        end
        default: begin
          if (scan_line == cmp_line) begin
            flags = flags | RASTER_FLAGS;
            res.raster_match = 1'b1;
          end
        end
      endcase
      // badline: display window, yscroll match and display enable
      ctl = regs[REG_CONTROL];
      res.badline = (scan_line >= BADLINE_FIRST) && (scan_line <= BADLINE_LAST) &&
                    (ctl[2:0] == scan_line[2:0]) && ctl[4];
      res.scanline = scan_line;
      owed.push_back(res);
    endfunction

    function void compare_field(string name, logic [8:0] want, logic [8:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 40)
          $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    // compare an accepted result with the oldest one owed
    function void check_item(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t unexpected result: expected none actual %h", $time, got);
        return;
      end
      want = owed.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("raster_match", want.raster_match, got.raster_match);
      compare_field("badline", want.badline, got.badline);
      compare_field("scanline", want.scanline, got.scanline);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  raster_irq_tracker sb;
  int unsigned       items_sent;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  bit                pressure_on;

  raster_line_irq_register_block dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // offer one item, with a random gap first, and note it once accepted
  task automatic send_item(op_e op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    in_item_t it;
    it.opcode     = op;
    it.reg_index  = idx;
    it.write_data = data;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    items_sent++;
  endtask

  // any byte for operations that ignore write_data
  function automatic logic [DATA_W-1:0] noise_byte();
    return DATA_W'($urandom_range(255));
  endfunction

  // result side: check accepted items, stall at random, one long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left   = 0;
    held        = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_item(out_data_o);
      if (pressure_on && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin : quiet_watch
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout at %0t", $time);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int unsigned       pick;
    int unsigned       tgt;
    logic [LINE_W-1:0] tline;
    logic [IDX_W-1:0]  specials [4];

    specials[0] = REG_CONTROL;
    specials[1] = REG_RASTER;
    specials[2] = REG_STATUS;
    specials[3] = REG_MASK;

    sb            = new();
    items_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_on   = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset values, match at line zero, status clear, mask, compare bit 8
    send_item(OP_READ, REG_CONTROL, 8'hff);
    send_item(OP_CHECK, 6'd0, 8'h00);
    send_item(OP_READ, REG_STATUS, 8'h00);
    send_item(OP_WRITE, REG_STATUS, 8'h01);
    send_item(OP_READ, REG_STATUS, 8'hff);
    send_item(OP_WRITE, REG_STATUS, 8'hff);
    send_item(OP_READ, REG_STATUS, 8'h00);
    send_item(OP_WRITE, REG_MASK, 8'hff);
    send_item(OP_READ, REG_MASK, 8'h00);
    send_item(OP_WRITE, REG_CONTROL, 8'h9b);
    send_item(OP_READ, REG_CONTROL, 8'h00);
    send_item(OP_CHECK, 6'd63, 8'hff);
    send_item(OP_WRITE, REG_RASTER, 8'hff);
    send_item(OP_WRITE, REG_CONTROL, 8'h00);
    send_item(OP_READ, REG_RASTER, 8'h00);
    // edges of the file and indexes beyond it
    send_item(OP_WRITE, 6'd48, 8'hff);
    send_item(OP_READ, 6'd48, 8'h00);
    send_item(OP_WRITE, 6'd49, 8'haa);
    send_item(OP_READ, 6'd49, 8'h00);
    send_item(OP_WRITE, 6'd63, 8'h55);
    send_item(OP_READ, 6'd63, 8'hff);
    send_item(OP_WRITE, 6'd0, 8'ha5);
    send_item(OP_READ, 6'd0, 8'h5a);
    send_item(OP_ADVANCE, 6'd0, 8'h00);
    send_item(OP_CHECK, 6'd0, 8'h00);

    // random: mostly line advances and checks, with compare loads aimed at the scanline
    while (items_sent < ITEM_TOTAL) begin
      if (items_sent < 420) begin
        send_idle_pct = 30;
        recv_idle_pct = 60;
      end else if (items_sent < 820) begin
        send_idle_pct = 60;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (items_sent >= 860)
          pressure_on = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        // load compare line a few lines ahead, then walk towards it and check
        tgt   = (sb.scan_line + $urandom_range(3)) % LINES_PER_FRAME;
        tline = tgt[LINE_W-1:0];
        send_item(OP_WRITE, REG_CONTROL, {tline[8], 2'($urandom_range(3)),
                  ($urandom_range(3) != 0), 4'($urandom_range(15))});
        send_item(OP_WRITE, REG_RASTER, tline[7:0]);
        repeat ($urandom_range(4))
          send_item($urandom_range(1) ? OP_ADVANCE : OP_CHECK, IDX_W'($urandom_range(63)),
                    noise_byte());
        send_item(OP_CHECK, IDX_W'($urandom_range(63)), noise_byte());
      end else if (pick < 50) begin
        send_item(OP_ADVANCE, IDX_W'($urandom_range(63)), noise_byte());
      end else if (pick < 62) begin
        send_item(OP_CHECK, IDX_W'($urandom_range(63)), noise_byte());
      end else if (pick < 74) begin
        send_item(OP_READ, IDX_W'($urandom_range(63)), noise_byte());
      end else if (pick < 84) begin
        send_item(OP_WRITE, IDX_W'($urandom_range(63)), noise_byte());
      end else if (pick < 92) begin
        send_item(OP_READ, specials[$urandom_range(3)], noise_byte());
      end else begin
        send_item(OP_WRITE, $urandom_range(1) ? REG_STATUS : REG_MASK, noise_byte());
      end
    end
    in_valid_i <= 1'b0;

    // drain outstanding results, then allow for late extras
    while (sb.owed.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
design/rlirq_pkg.sv
design/rlirq_regfile.sv
design/rlirq_exec.sv
design/raster_line_irq_register_block.sv
tb/tb_top.sv
